// ===== hw/rtl/davp_pkg.sv =====
// ----------------------------------------------------------------------------
// davp_pkg
// Shared types and constants for the Diameter AVP finder: header geometry,
// result status codes and the result record passed from the core to the top.
// ----------------------------------------------------------------------------
`default_nettype none

package davp_pkg;

  // Width of buffer lengths and offsets
  localparam int LENGTH_BITS  = 16;
  // Fixed AVP header size in bytes
  localparam int HEADER_BYTES = 8;
  // Header byte index width (values 0 .. HEADER_BYTES-1)
  localparam int IDX_BITS     = $clog2(HEADER_BYTES);
  // AVP length field width and padded-length width
  localparam int AVP_LEN_BITS = 24;
  localparam int PAD_BITS     = AVP_LEN_BITS + 1;
  // Payload alignment of AVPs
  localparam int PAD_UNIT     = 4;

  // Header byte positions of interest
  localparam logic [IDX_BITS-1:0] IDX_CODE_LAST = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] IDX_LEN_FIRST = IDX_BITS'(5);
  localparam logic [IDX_BITS-1:0] IDX_HDR_LAST  = IDX_BITS'(HEADER_BYTES - 1);

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_INVALID   = 2'd2
  } status_t;

  // One search outcome, valid when hit is set
  typedef struct packed {
    logic                   hit;
    status_t                status;
    logic [LENGTH_BITS-1:0] offset;
    logic [LENGTH_BITS-1:0] length;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/diameter_avp_finder_top.sv =====
// ----------------------------------------------------------------------------
// diameter_avp_finder_top
// Streaming search of a Diameter AVP buffer for one AVP code, reporting
// found (with offset and length), not found, or invalid AVP length.
//
//  Channel | Dir | tdata                                   | tuser      | tlast
//  s_*     | in  | data_byte, buffer_length, target_code   | first_byte | last_byte
//  m_*     | out | avp_offset, avp_total_length            | status     | -
//
// One byte is taken per cycle while s_tready is high. The core handles each
// byte combinationally and its result is registered on the edge that accepts
// the byte, so m_tvalid rises in the cycle after the input transaction.
// At most one result per buffer, emitted on the byte that decides it.
// Reset (rst, synchronous) holds s_tready low and leaves the block idle until
// a first byte.
// s_tready drops only during reset or while a result waits in the output
// register and m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module diameter_avp_finder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // [7:0] data_byte, [23:8] buffer_length,
                                      // [55:24] target_code
  input  wire logic        s_tuser,   // [0] first_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] avp_offset, [31:16] avp_total_length
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int LB = davp_pkg::LENGTH_BITS;

  logic              accept;
  davp_pkg::result_t core_res;
  davp_pkg::status_t status;
  logic [LB-1:0]     avp_offset;
  logic [LB-1:0]     avp_total_length;

  // Input transaction taken whenever the result slot is free or draining
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  davp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .en            (accept),
    .data_byte     (s_tdata[7:0]),
    .first_byte    (s_tuser),
    .last_byte     (s_tlast),
    .buffer_length (s_tdata[23:8]),
    .target_code   (s_tdata[55:24]),
    .res           (core_res)
  );

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= core_res.hit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept && core_res.hit) begin
      status           <= core_res.status;
      avp_offset       <= core_res.offset;
      avp_total_length <= core_res.length;
    end
  end

  assign m_tdata = {avp_total_length, avp_offset};
  assign m_tuser = status;

  // A found AVP always has at least a full header
  a_found_len : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == davp_pkg::ST_FOUND) |->
      avp_total_length >= LB'(davp_pkg::HEADER_BYTES))
    else $error("found AVP shorter than its header");

  // Non-found outcomes carry zero offset and length
  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != davp_pkg::ST_FOUND) |->
      (avp_offset == '0 && avp_total_length == '0))
    else $error("non-found result with nonzero payload");

  // No input taken while a result is stalled
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted over a stalled result");

  // A stalled result survives into the next cycle
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result lost");

endmodule

`default_nettype wire

// ===== hw/rtl/davp_core.sv =====
// ----------------------------------------------------------------------------
// davp_core
// Per-byte search engine: header shift registers, skip counter and the
// end-of-header decision. Each accepted byte updates the state registers
// and may raise a result for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module davp_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            first_byte,
  input  wire logic                            last_byte,
  input  wire logic [davp_pkg::LENGTH_BITS-1:0] buffer_length,
  input  wire logic [31:0]                     target_code,
  output davp_pkg::result_t                    res
);

  localparam int LB = davp_pkg::LENGTH_BITS;
  localparam int IB = davp_pkg::IDX_BITS;
  localparam int AB = davp_pkg::AVP_LEN_BITS;
  localparam int PB = davp_pkg::PAD_BITS;

  // Search state
  logic [31:0]   wanted_code,       wanted_code_next;
  logic [LB-1:0] total_bytes,       total_bytes_next;
  logic [LB-1:0] bytes_left,        bytes_left_next;
  logic [LB-1:0] current_avp_start, current_avp_start_next;
  logic [IB-1:0] header_byte_index, header_byte_index_next;
  logic [31:0]   code_shift,        code_shift_next;
  logic [AB-1:0] length_shift,      length_shift_next;
  logic [PB-1:0] skip_count,        skip_count_next;
  logic          code_match,        code_match_next;
  logic          search_done,       search_done_next;

  // Next-state and result logic for one byte
  always_comb begin
    logic          code_eq;
    logic [PB-1:0] padded;
    logic [LB-1:0] left_after;

    wanted_code_next       = wanted_code;
    total_bytes_next       = total_bytes;
    bytes_left_next        = bytes_left;
    current_avp_start_next = current_avp_start;
    header_byte_index_next = header_byte_index;
    code_shift_next        = code_shift;
    length_shift_next      = length_shift;
    skip_count_next        = skip_count;
    code_match_next        = code_match;
    search_done_next       = search_done;
    res                    = '0;
    res.status             = davp_pkg::ST_FOUND;
    code_eq                = 1'b0;
    padded                 = '0;
    left_after             = '0;

    // First byte: sample length and code, restart the search
    if (first_byte) begin
      wanted_code_next       = target_code;
      total_bytes_next       = buffer_length;
      bytes_left_next        = buffer_length;
      current_avp_start_next = '0;
      header_byte_index_next = '0;
      code_shift_next        = '0;
      length_shift_next      = '0;
      skip_count_next        = '0;
      code_match_next        = 1'b0;
      search_done_next       = 1'b0;
      if (buffer_length < LB'(davp_pkg::HEADER_BYTES)) begin
        res.hit          = 1'b1;
        res.status       = davp_pkg::ST_NOT_FOUND;
        search_done_next = 1'b1;
      end
    end

    if (!search_done_next) begin
      if (skip_count_next != '0) begin
        // Skipping payload of a non-matching AVP
        skip_count_next = skip_count_next - PB'(1);
      end else begin
        // Header byte, network order
        code_shift_next = {code_shift_next[23:0], data_byte};
        if (header_byte_index_next >= davp_pkg::IDX_LEN_FIRST) begin
          length_shift_next = {length_shift_next[AB-9:0], data_byte};
        end
        code_eq = (code_shift_next == wanted_code_next);
        if (header_byte_index_next == davp_pkg::IDX_CODE_LAST) begin
          code_match_next = code_eq;
        end

        if (header_byte_index_next == davp_pkg::IDX_HDR_LAST) begin
          // End of header: decide on this AVP
          header_byte_index_next = '0;
          if (code_match_next) begin
            res.hit = 1'b1;
            if (length_shift_next > AB'(total_bytes_next) ||
                length_shift_next < AB'(davp_pkg::HEADER_BYTES)) begin
              res.status = davp_pkg::ST_INVALID;
            end else begin
              res.status = davp_pkg::ST_FOUND;
              res.offset = current_avp_start_next;
              res.length = length_shift_next[LB-1:0];
            end
          end else if (length_shift_next == '0) begin
            res.hit    = 1'b1;
            res.status = davp_pkg::ST_INVALID;
          end else begin
            padded = (PB'(length_shift_next) + PB'(davp_pkg::PAD_UNIT - 1)) &
                     ~PB'(davp_pkg::PAD_UNIT - 1);
            if (padded >= PB'(bytes_left_next)) begin
              left_after = '0;
            end else begin
              left_after = bytes_left_next - padded[LB-1:0];
            end
            bytes_left_next        = left_after;
            current_avp_start_next = current_avp_start_next + padded[LB-1:0];
            if (left_after < LB'(davp_pkg::HEADER_BYTES)) begin
              res.hit    = 1'b1;
              res.status = davp_pkg::ST_NOT_FOUND;
            end else if (padded < PB'(davp_pkg::HEADER_BYTES)) begin
              // Short AVP: next header started at this one's fifth byte
              header_byte_index_next = IB'(davp_pkg::HEADER_BYTES - davp_pkg::PAD_UNIT);
              code_match_next        = code_eq;
            end else begin
              skip_count_next = padded - PB'(davp_pkg::HEADER_BYTES);
            end
          end
        end else begin
          header_byte_index_next = header_byte_index_next + IB'(1);
        end
      end

      // Buffer ended without a decision
      if (!res.hit && last_byte) begin
        res.hit    = 1'b1;
        res.status = davp_pkg::ST_NOT_FOUND;
      end
      if (res.hit) begin
        search_done_next = 1'b1;
      end
    end
  end

  // State registers, advanced per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_code       <= '0;
      total_bytes       <= '0;
      bytes_left        <= '0;
      current_avp_start <= '0;
      header_byte_index <= '0;
      code_shift        <= '0;
      length_shift      <= '0;
      skip_count        <= '0;
      code_match        <= 1'b0;
      search_done       <= 1'b1;
    end else if (en) begin
      wanted_code       <= wanted_code_next;
      total_bytes       <= total_bytes_next;
      bytes_left        <= bytes_left_next;
      current_avp_start <= current_avp_start_next;
      header_byte_index <= header_byte_index_next;
      code_shift        <= code_shift_next;
      length_shift      <= length_shift_next;
      skip_count        <= skip_count_next;
      code_match        <= code_match_next;
      search_done       <= search_done_next;
    end
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for diameter_avp_finder_top. Byte streams holding
// Diameter AVP buffers (matching, skipped, zero-length, short, oversize and
// truncated AVPs) are driven into the slave port. A scoreboard tracks the
// search state byte by byte and compares each search outcome on the master
// port with its own prediction. Both ports idle at random.
// ----------------------------------------------------------------------------

module testbench;

  localparam int ITEM_TARGET = 1750;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;

  // One predicted search outcome
  typedef struct {
    davp_pkg::status_t status;
    logic [15:0]       offset;
    logic [15:0]       length;
  } avp_outcome_t;

  // Scoreboard: tracks the search per accepted byte, checks outcomes in order
  class avp_scoreboard;
    avp_outcome_t   outcome_q[$];
    int             errors;
    // search state
    logic [31:0]    want;
    logic [15:0]    total;
    int unsigned    left;
    logic [15:0]    start;
    int unsigned    idx;
    logic [31:0]    code_sr;
    logic [23:0]    len_sr;
    int unsigned    skip;
    bit             hit;
    bit             idle;

    function new();
      errors = 0;
      want = '0;
      total = '0;
      left = 0;
      start = '0;
      idx = 0;
      code_sr = '0;
      len_sr = '0;
      skip = 0;
      hit = 1'b0;
      idle = 1'b1;
    endfunction

    function void log_error(string text);
      errors++;
      if (errors <= 10) $display("%s", text);
    endfunction

    // Queue an outcome and close the search
    function bit conclude_search(davp_pkg::status_t st, logic [15:0] off,
                                 logic [15:0] len);
      avp_outcome_t res;
      res.status = st;
      res.offset = off;
      res.length = len;
      outcome_q.push_back(res);
      idle = 1'b1;
      return 1'b1;
    endfunction

    // Decide on a complete header: report, or skip to the next AVP
    function bit close_header();
      int unsigned avp_len;
      int unsigned padded;
      avp_len = len_sr;
      idx = 0;
      if (hit) begin
        if (avp_len > total || avp_len < davp_pkg::HEADER_BYTES)
          return conclude_search(davp_pkg::ST_INVALID, '0, '0);
        return conclude_search(davp_pkg::ST_FOUND, start, avp_len[15:0]);
      end
      if (avp_len == 0) return conclude_search(davp_pkg::ST_INVALID, '0, '0);
      padded = (avp_len + davp_pkg::PAD_UNIT - 1) & ~(davp_pkg::PAD_UNIT - 1);
      if (padded >= left) left = 0;
      else left = left - padded;
      start = start + padded[15:0];
      if (left < davp_pkg::HEADER_BYTES)
        return conclude_search(davp_pkg::ST_NOT_FOUND, '0, '0);
      if (padded < davp_pkg::HEADER_BYTES) begin
        // next header overlaps this one: its code is already shifted in
        idx = davp_pkg::HEADER_BYTES - padded;
        hit = (code_sr == want);
      end else begin
        skip = padded - davp_pkg::HEADER_BYTES;
      end
      return 1'b0;
    endfunction

    // Accepted input transaction
    function void note_byte(logic [7:0] b, logic first, logic last, logic [15:0] blen,
                            logic [31:0] code);
      bit done;
      done = 1'b0;
      if (first) begin
        want = code;
        total = blen;
        left = blen;
        start = '0;
        idx = 0;
        code_sr = '0;
        len_sr = '0;
        skip = 0;
        hit = 1'b0;
        idle = 1'b0;
        if (left < davp_pkg::HEADER_BYTES) begin
          done = conclude_search(davp_pkg::ST_NOT_FOUND, '0, '0);
          return;
        end
      end
      if (idle) return;
      if (skip != 0) begin
        skip--;
      end else begin
        code_sr = {code_sr[23:0], b};
        if (idx >= davp_pkg::IDX_LEN_FIRST) len_sr = {len_sr[15:0], b};
        if (idx == davp_pkg::IDX_CODE_LAST) hit = (code_sr == want);
        idx = idx + 1;
        if (idx >= davp_pkg::HEADER_BYTES) done = close_header();
      end
      // early end of buffer
      if (!done && last) done = conclude_search(davp_pkg::ST_NOT_FOUND, '0, '0);
    endfunction

    // Accepted output transaction
    function void check_outcome(logic [1:0] st, logic [15:0] off, logic [15:0] len);
      avp_outcome_t exp;
      if (outcome_q.size() == 0) begin
        log_error($sformatf("ERROR: unexpected outcome status=%0d offset=%0d length=%0d",
                            st, off, len));
        return;
      end
      exp = outcome_q.pop_front();
      if (st !== exp.status || off !== exp.offset || len !== exp.length)
        log_error($sformatf({"ERROR: outcome mismatch: expected status=%0d offset=%0d ",
                             "length=%0d, got status=%0d offset=%0d length=%0d"},
                            exp.status, exp.offset, exp.length, st, off, len));
    endfunction

    function void check_drained();
      while (outcome_q.size() != 0) begin
        log_error($sformatf("ERROR: outcome never arrived: status=%0d offset=%0d length=%0d",
                            outcome_q[0].status, outcome_q[0].offset,
                            outcome_q[0].length));
        void'(outcome_q.pop_front());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // [7:0] data_byte, [23:8] buffer_length, [55:24] target_code
  logic        s_tuser = 1'b0; // [0] first_byte
  logic        s_tlast = 1'b0; // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [15:0] avp_offset, [31:16] avp_total_length
  logic [1:0]  m_tuser;        // [1:0] status

  avp_scoreboard sb = new();
  logic [7:0]    frame_q[$];
  int            items_sent = 0;
  int            send_idle_pct = 13;
  int            recv_idle_pct = 88;
  bit            hold_request = 1'b0;
  int            stall_cycles = 0;

  diameter_avp_finder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one byte and wait for its transaction
  task automatic drive_byte(input logic [7:0] b, input logic first, input logic last,
                            input logic [15:0] blen, input logic [31:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {code, blen, b};
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_header(input logic [31:0] code, input logic [7:0] flags,
                             input logic [23:0] len);
    frame_q.push_back(code[31:24]);
    frame_q.push_back(code[23:16]);
    frame_q.push_back(code[15:8]);
    frame_q.push_back(code[7:0]);
    frame_q.push_back(flags);
    frame_q.push_back(len[23:16]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
  endtask

  // Send nbytes of the buffer; bytes past its end are random
  task automatic send_frame(input logic [15:0] blen, input logic [31:0] code,
                            input int nbytes, input bit with_last);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      b = (i < frame_q.size()) ? frame_q[i] : 8'($urandom());
      if (i == 0) drive_byte(b, 1'b1, with_last && nbytes == 1, blen, code);
      else drive_byte(b, 1'b0, with_last && i == nbytes - 1, 16'($urandom()), $urandom());
    end
  endtask

  // Random AVP buffer, mostly well formed, with some odd lengths
  task automatic build_frame(input logic [31:0] target);
    int          n;
    int          sel;
    logic [31:0] c;
    int unsigned len;
    int unsigned pad;
    frame_q.delete();
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) c = target;
      else if (sel == 1) c = target ^ (32'd1 << $urandom_range(0, 31));
      else c = $urandom();
      sel = $urandom_range(0, 19);
      if (sel == 0) len = 0;
      else if (sel <= 2) len = $urandom_range(1, 7);
      else if (sel == 3) len = $urandom_range(41, 24'hFFFFFF);
      else len = $urandom_range(8, 40);
      push_header(c, 8'($urandom()), len[23:0]);
      if (len >= davp_pkg::HEADER_BYTES && len <= 40) begin
        pad = ((len + davp_pkg::PAD_UNIT - 1) & ~(davp_pkg::PAD_UNIT - 1)) -
              davp_pkg::HEADER_BYTES;
        repeat (pad) frame_q.push_back(8'($urandom()));
      end
    end
    if (frame_q.size() == 0) frame_q.push_back(8'($urandom()));
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Transaction monitor and stall counter
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_outcome(m_tuser, m_tdata[15:0], m_tdata[31:16]);
      if (s_tvalid && s_tready)
        sb.note_byte(s_tdata[7:0], s_tuser, s_tlast, s_tdata[23:8], s_tdata[55:24]);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    logic [31:0] target;
    logic [15:0] blen;
    int          size;
    int          sel;
    int          nbytes;
    int          phase;
    phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // byte while idle, last set: ignored
    drive_byte(8'hFF, 1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    // buffer shorter than a header
    drive_byte(8'h00, 1'b1, 1'b1, 16'd3, 32'h0000_0000);
    // matching AVP with length 0: invalid; widest length and code
    frame_q.delete();
    push_header(32'hFFFF_FFFF, 8'hFF, 24'd0);
    send_frame(16'hFFFF, 32'hFFFF_FFFF, 8, 1'b0);
    // zero-length non-matching AVP: invalid
    frame_q.delete();
    push_header(32'h0000_0001, 8'h00, 24'd0);
    send_frame(16'd20, 32'h0000_0000, 8, 1'b0);
    // search abandoned by a new first byte, then an early end
    frame_q.delete();
    push_header(32'h0000_0005, 8'h40, 24'd16);
    send_frame(16'd16, 32'h0000_0005, 2, 1'b0);
    send_frame(16'd100, 32'h0000_0005, 3, 1'b1);

    // Random buffers
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 1200 && phase < 2) begin
        phase = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
      end else if (items_sent >= 600 && phase < 1) begin
        phase = 1;
        send_idle_pct = 88;
        recv_idle_pct = 13;
      end
      // noise between buffers
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3))
          drive_byte(8'($urandom()), 1'b0, 1'($urandom()), 16'($urandom()), $urandom());
      target = $urandom();
      build_frame(target);
      size = frame_q.size();
      sel = $urandom_range(0, 9);
      if (sel < 6) blen = size[15:0];
      else if (sel == 6) blen = 16'($urandom());
      else if (sel == 7) blen = 16'($urandom_range(0, 7));
      else if (sel == 8) blen = 16'(size - $urandom_range(0, size));
      else blen = 16'(size + $urandom_range(1, 16));
      sel = $urandom_range(0, 9);
      if (sel < 7) nbytes = size;
      else if (sel == 7) nbytes = $urandom_range(1, size);
      else if (sel == 8) nbytes = size + $urandom_range(1, 6);
      else nbytes = size;
      send_frame(blen, target, nbytes, sel != 9);
    end
    s_tvalid <= 1'b0;

    // Drain
    while (sb.outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/davp_pkg.sv
hw/rtl/davp_core.sv
hw/rtl/diameter_avp_finder_top.sv
bench/testbench.sv
